/* sv/ascii_art_horizontal_smush_assert.svh */
// Assertion macros used by the port-level checker of the horizontal smush block.
// No dependencies; include by bare file name.
`ifndef ASCII_ART_HORIZONTAL_SMUSH_ASSERT_SVH
`define ASCII_ART_HORIZONTAL_SMUSH_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define AAHS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define AAHS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked through reset.
`define AAHS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/aahs_pkg.sv */
// Types, character codes and the bracket class table for the horizontal smush block.
// No dependencies.
package aahs_pkg;

   localparam int CodeWidth    = 21;
   localparam int RuleWidth    = 6;
   localparam int ReqDataWidth = 48;
   localparam int RspDataWidth = 24;

   localparam logic [CodeWidth-1:0] CharBar       = 21'h00007C;
   localparam logic [CodeWidth-1:0] CharSlash     = 21'h00002F;
   localparam logic [CodeWidth-1:0] CharBackslash = 21'h00005C;
   localparam logic [CodeWidth-1:0] CharLBracket  = 21'h00005B;
   localparam logic [CodeWidth-1:0] CharRBracket  = 21'h00005D;
   localparam logic [CodeWidth-1:0] CharLBrace    = 21'h00007B;
   localparam logic [CodeWidth-1:0] CharRBrace    = 21'h00007D;
   localparam logic [CodeWidth-1:0] CharLParen    = 21'h000028;
   localparam logic [CodeWidth-1:0] CharRParen    = 21'h000029;
   localparam logic [CodeWidth-1:0] CharLess      = 21'h00003C;
   localparam logic [CodeWidth-1:0] CharGreater   = 21'h00003E;
   localparam logic [CodeWidth-1:0] CharUnderline = 21'h00005F;
   localparam logic [CodeWidth-1:0] CharY         = 21'h000059;
   localparam logic [CodeWidth-1:0] CharX         = 21'h000058;
   localparam logic [CodeWidth-1:0] CharHardblank = 21'h0000A0;

   // Bit positions in the rule enable mask.
   localparam int RuleEqual      = 0;
   localparam int RuleUnderline  = 1;
   localparam int RuleHierarchy  = 2;
   localparam int RuleOpposite   = 3;
   localparam int RuleBigX       = 4;
   localparam int RuleHardblank  = 5;

   typedef logic [2:0] bracket_class_type;
   localparam bracket_class_type ClassNone = 3'd7;

   typedef struct packed {
      logic                 smushed;
      logic [CodeWidth-1:0] merged_char;
   } smush_result_type;

   // Rank in the bracket hierarchy, or ClassNone for any other character.
   function automatic bracket_class_type bracket_class(input logic [CodeWidth-1:0] c);
      bracket_class_type cls;
      unique case (c)
         CharBar:                     cls = 3'd0;
         CharSlash, CharBackslash:    cls = 3'd1;
         CharLBracket, CharRBracket:  cls = 3'd2;
         CharLBrace, CharRBrace:      cls = 3'd3;
         CharLParen, CharRParen:      cls = 3'd4;
         CharLess, CharGreater:       cls = 3'd5;
         default:                     cls = ClassNone;
      endcase
      return cls;
   endfunction

endpackage

/* sv/ascii_art_horizontal_smush.sv */
// Top level of the horizontal smush block: request register, decision logic, result register.
// Depends on aahs_pkg and aahs_decide.
//
// Each request carries the character already on the canvas and the incoming character at one
// overlap position; the block answers with the merged character and a flag telling whether an
// enabled rule merged them. One request is taken every cycle while the result side does not
// stall; each request is held in the request register, decided by the single decision stage
// that sits between it and the result register, and presented from the result register. The
// rule mask is written through the csr channel, which is always ready, and should only change
// while no request is in flight.
module ascii_art_horizontal_smush (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [aahs_pkg::RuleWidth-1:0]    csr_data,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // Fields from bit 0: left_char[20:0], right_char[41:21], zero padding.
   input  logic [aahs_pkg::ReqDataWidth-1:0] req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // Fields from bit 0: merged_char[20:0], zero padding.
   output logic [aahs_pkg::RspDataWidth-1:0] rsp_tdata,
   // Fields from bit 0: smushed.
   output logic                              rsp_tuser
);
   import aahs_pkg::*;

   logic                 in_valid_ff, in_valid_in;
   logic                 out_valid_ff, out_valid_in;
   logic [RuleWidth-1:0] rules_ff, rules_in;
   logic [CodeWidth-1:0] left_ff;
   logic [CodeWidth-1:0] right_ff;
   smush_result_type     result_ff;
   smush_result_type     result_in;
   logic                 req_load;
   logic                 out_load;

   assign out_load   = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || out_load;
   assign req_load   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign in_valid_in  = req_load || (in_valid_ff && !out_load);
   assign out_valid_in = out_load || (out_valid_ff && !rsp_tready);
   assign rules_in     = csr_valid ? csr_data : rules_ff;

   aahs_decide u_decide (
      .left_char   (left_ff),
      .right_char  (right_ff),
      .smush_rules (rules_ff),
      .result      (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         rules_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         rules_ff     <= rules_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_load) begin
         left_ff  <= req_tdata[CodeWidth-1:0];
         right_ff <= req_tdata[2*CodeWidth-1:CodeWidth];
      end
      if (out_load) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RspDataWidth-CodeWidth){1'b0}}, result_ff.merged_char};
   assign rsp_tuser  = result_ff.smushed;

endmodule

/* sv/aahs_decide.sv */
// Single-pass smushing decision for one pair of overlapping characters.
// Depends on aahs_pkg for character codes, rule positions and the class table.
module aahs_decide (
   input  logic [aahs_pkg::CodeWidth-1:0] left_char,
   input  logic [aahs_pkg::CodeWidth-1:0] right_char,
   input  logic [aahs_pkg::RuleWidth-1:0] smush_rules,
   output aahs_pkg::smush_result_type     result
);
   import aahs_pkg::*;

   logic              both_ascii;
   logic              both_members;
   logic              opposite_pair;
   bracket_class_type left_class;
   bracket_class_type right_class;

   assign both_ascii   = (left_char[CodeWidth-1:7] == '0) && (right_char[CodeWidth-1:7] == '0);
   assign left_class   = bracket_class(left_char);
   assign right_class  = bracket_class(right_char);
   assign both_members = (left_class != ClassNone) && (right_class != ClassNone);

   assign opposite_pair =
      (left_char == CharLBracket && right_char == CharRBracket) ||
      (left_char == CharRBracket && right_char == CharLBracket) ||
      (left_char == CharLBrace   && right_char == CharRBrace)   ||
      (left_char == CharRBrace   && right_char == CharLBrace)   ||
      (left_char == CharLParen   && right_char == CharRParen)   ||
      (left_char == CharRParen   && right_char == CharLParen);

   always_comb begin
      result = '0;
      if (smush_rules[RuleEqual] && left_char == right_char && left_char != CharHardblank) begin
         result = '{smushed: 1'b1, merged_char: right_char};
      end else if (both_ascii && smush_rules[RuleUnderline] && left_char == CharUnderline &&
                   right_class != ClassNone) begin
         result = '{smushed: 1'b1, merged_char: right_char};
      end else if (both_ascii && smush_rules[RuleUnderline] && right_char == CharUnderline &&
                   left_class != ClassNone) begin
         result = '{smushed: 1'b1, merged_char: left_char};
      end else if (both_ascii && smush_rules[RuleHierarchy] && both_members &&
                   left_class < right_class) begin
         result = '{smushed: 1'b1, merged_char: right_char};
      end else if (both_ascii && smush_rules[RuleHierarchy] && both_members &&
                   left_class > right_class) begin
         result = '{smushed: 1'b1, merged_char: left_char};
      end else if (both_ascii && smush_rules[RuleOpposite] && opposite_pair) begin
         result = '{smushed: 1'b1, merged_char: CharBar};
      end else if (both_ascii && smush_rules[RuleBigX] && left_char == CharSlash &&
                   right_char == CharBackslash) begin
         result = '{smushed: 1'b1, merged_char: CharBar};
      end else if (both_ascii && smush_rules[RuleBigX] && left_char == CharBackslash &&
                   right_char == CharSlash) begin
         result = '{smushed: 1'b1, merged_char: CharY};
      end else if (both_ascii && smush_rules[RuleBigX] && left_char == CharGreater &&
                   right_char == CharLess) begin
         result = '{smushed: 1'b1, merged_char: CharX};
      end else if (smush_rules[RuleHardblank] && left_char == CharHardblank &&
                   right_char == CharHardblank) begin
         result = '{smushed: 1'b1, merged_char: CharHardblank};
      end
   end

endmodule

/* sv/aahs_checker.sv */
// Port-level checks for the horizontal smush block, attached to the top level by bind.
// Depends on aahs_pkg and ascii_art_horizontal_smush_assert.svh.
`include "ascii_art_horizontal_smush_assert.svh"

module aahs_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [aahs_pkg::RspDataWidth-1:0] rsp_tdata,
   input logic                              rsp_tuser
);
   import aahs_pkg::*;

   `AAHS_ASSERT_IMPLY(a_no_merge_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0, "Unmerged result carries a non-zero code")
   `AAHS_ASSERT_IMPLY(a_ready_when_free, clock, reset, !rsp_tvalid || rsp_tready, req_tready, "Request side stalled although the result side is free")
   `AAHS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "Stalled result changed or vanished")
   `AAHS_ASSERT_NEXT_ALWAYS(a_reset_clears, clock, reset, !rsp_tvalid, "Result valid straight after reset")

endmodule

bind ascii_art_horizontal_smush aahs_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

/* test/tb_ascii_art_horizontal_smush.sv */
// Self-checking testbench for ascii_art_horizontal_smush: random and directed character pairs
// run under several rule masks against a behavioural prediction of the smushing rules.
// Depends on aahs_pkg and the ascii_art_horizontal_smush RTL.
module tb_ascii_art_horizontal_smush;
   import aahs_pkg::*;

   typedef logic [CodeWidth-1:0] code_type;

   localparam code_type AsciiLimit = 21'h000080;
   localparam int       CycleLimit = 200000;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [RuleWidth-1:0]    csr_data;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic                    rsp_tuser;

   logic [RuleWidth-1:0] rule_mask = '0;
   smush_result_type     pending_merges[$];
   int                   mismatch_count = 0;
   int                   cycle_count = 0;
   bit                   idle_on = 1'b1;

   ascii_art_horizontal_smush uut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Rank in the bracket hierarchy; -1 for characters outside the set.
   function automatic int hierarchy_rank(input code_type c);
      case (c)
         CharBar:                    return 0;
         CharSlash, CharBackslash:   return 1;
         CharLBracket, CharRBracket: return 2;
         CharLBrace, CharRBrace:     return 3;
         CharLParen, CharRParen:     return 4;
         CharLess, CharGreater:      return 5;
         default:                    return -1;
      endcase
   endfunction

   function automatic smush_result_type predict_smush(input code_type left,
                                                      input code_type right,
                                                      input logic [RuleWidth-1:0] mask);
      smush_result_type res;
      int rank_l;
      int rank_r;
      res = '{smushed: 1'b1, merged_char: '0};
      rank_l = hierarchy_rank(left);
      rank_r = hierarchy_rank(right);
      if (mask[RuleEqual] && left == right && left != CharHardblank) begin
         res.merged_char = right;
         return res;
      end
      if (left < AsciiLimit && right < AsciiLimit) begin
         if (mask[RuleUnderline]) begin
            if (left == CharUnderline && rank_r >= 0) begin
               res.merged_char = right;
               return res;
            end
            if (right == CharUnderline && rank_l >= 0) begin
               res.merged_char = left;
               return res;
            end
         end
         if (mask[RuleHierarchy] && rank_l >= 0 && rank_r >= 0 && rank_l != rank_r) begin
            res.merged_char = (rank_l < rank_r) ? right : left;
            return res;
         end
         if (mask[RuleOpposite]) begin
            if ((left == CharLBracket && right == CharRBracket) ||
                (left == CharRBracket && right == CharLBracket) ||
                (left == CharLBrace && right == CharRBrace) ||
                (left == CharRBrace && right == CharLBrace) ||
                (left == CharLParen && right == CharRParen) ||
                (left == CharRParen && right == CharLParen)) begin
               res.merged_char = CharBar;
               return res;
            end
         end
         if (mask[RuleBigX]) begin
            if (left == CharSlash && right == CharBackslash) begin
               res.merged_char = CharBar;
               return res;
            end
            if (left == CharBackslash && right == CharSlash) begin
               res.merged_char = CharY;
               return res;
            end
            if (left == CharGreater && right == CharLess) begin
               res.merged_char = CharX;
               return res;
            end
         end
      end
      if (mask[RuleHardblank] && left == CharHardblank && right == CharHardblank) begin
         res.merged_char = CharHardblank;
         return res;
      end
      return '{smushed: 1'b0, merged_char: '0};
   endfunction

   function automatic code_type pick_code();
      code_type specials[16];
      int sel;
      specials = '{CharBar, CharSlash, CharBackslash, CharLBracket, CharRBracket, CharLBrace,
                   CharRBrace, CharLParen, CharRParen, CharLess, CharGreater, CharUnderline,
                   CharHardblank, CharX, CharY, '0};
      sel = $urandom_range(99);
      if (sel < 45) return specials[$urandom_range(15)];
      if (sel < 70) return code_type'($urandom_range(127));
      if (sel < 80) return code_type'($urandom_range(255));
      if (sel < 97) return code_type'($urandom_range(21'h10FFFF));
      return code_type'($urandom_range(21'h1FFFFF));
   endfunction

   task automatic log_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%s", msg);
   endtask

   task automatic send_pair(input code_type left, input code_type right);
      while (idle_on && $urandom_range(99) < 21) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(ReqDataWidth - 2 * CodeWidth){1'b0}}, right, left};
      do @(posedge clock); while (!req_tready);
      pending_merges.push_back(predict_smush(left, right, rule_mask));
   endtask

   task automatic send_random_pairs(input int count);
      code_type left;
      repeat (count) begin
         left = pick_code();
         send_pair(left, ($urandom_range(99) < 20) ? left : pick_code());
      end
   endtask

   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_merges.size() != 0);
   endtask

   task automatic set_rules(input logic [RuleWidth-1:0] mask);
      csr_valid <= 1'b1;
      csr_data  <= mask;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      rule_mask = mask;
   endtask

   // After reset no rule is enabled, so nothing may merge.
   task automatic test_reset_mask();
      send_pair('0, '0);
      send_pair(CharHardblank, CharHardblank);
      send_pair(CharBar, CharBar);
      send_pair(CharSlash, CharBackslash);
      wait_results_drained();
   endtask

   task automatic test_directed_pairs();
      set_rules('1);
      send_pair('0, '0);
      send_pair('0, CharBar);
      send_pair(21'h10FFFF, 21'h10FFFF);
      send_pair(21'h1FFFFF, 21'h1FFFFF);
      send_pair(21'h1FFFFF, '0);
      send_pair(CharHardblank, CharHardblank);
      send_pair(CharUnderline, CharBar);
      send_pair(CharLParen, CharUnderline);
      send_pair(CharBar, CharSlash);
      send_pair(CharGreater, CharLBrace);
      send_pair(CharLBracket, CharRBracket);
      send_pair(CharRBrace, CharLBrace);
      send_pair(CharRParen, CharLParen);
      send_pair(CharSlash, CharBackslash);
      send_pair(CharBackslash, CharSlash);
      send_pair(CharGreater, CharLess);
      send_pair(CharLess, CharGreater);
      send_pair(21'h00007F, 21'h000080);
      send_pair(CharHardblank, CharUnderline);
      wait_results_drained();
   endtask

   task automatic test_rule_masks();
      logic [RuleWidth-1:0] masks[11];
      masks = '{6'h00, 6'h01, 6'h02, 6'h04, 6'h08, 6'h10, 6'h20, 6'h3F,
                RuleWidth'($urandom_range(63)), RuleWidth'($urandom_range(63)),
                RuleWidth'($urandom_range(63))};
      foreach (masks[i]) begin
         set_rules(masks[i]);
         send_random_pairs(90);
         wait_results_drained();
      end
   endtask

   // The sender holds off in the middle of the phase until every result is back.
   task automatic test_sender_pause();
      set_rules(6'h1E);
      send_random_pairs(30);
      wait_results_drained();
      send_random_pairs(30);
      wait_results_drained();
   endtask

   task automatic test_back_to_back();
      idle_on = 1'b0;
      set_rules(6'h3F);
      send_random_pairs(200);
      wait_results_drained();
      idle_on = 1'b1;
   endtask

   always @(posedge clock) begin
      smush_result_type exp_res;
      rsp_tready <= !idle_on || ($urandom_range(99) >= 21);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_merges.size() == 0) begin
            log_mismatch($sformatf("unexpected result: merged_char %h smushed %b",
                                   rsp_tdata[CodeWidth-1:0], rsp_tuser));
         end else begin
            exp_res = pending_merges.pop_front();
            if (rsp_tdata[CodeWidth-1:0] !== exp_res.merged_char)
               log_mismatch($sformatf("merged_char: expected %h, got %h",
                                      exp_res.merged_char, rsp_tdata[CodeWidth-1:0]));
            if (rsp_tuser !== exp_res.smushed)
               log_mismatch($sformatf("smushed: expected %b, got %b",
                                      exp_res.smushed, rsp_tuser));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("** ascii_art_horizontal_smush: FAILED **");
         $finish;
      end
   end

   initial begin
      reset      <= 1'b1;
      csr_valid  <= 1'b0;
      csr_data   <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      rsp_tready <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_mask();
      test_directed_pairs();
      test_rule_masks();
      test_sender_pause();
      test_back_to_back();

      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** ascii_art_horizontal_smush: PASSED **");
      end else begin
         $display("** ascii_art_horizontal_smush: FAILED **");
      end
      $finish;
   end

endmodule
